[hdl/text_console_cell_writer_core_macros.svh]
// Assertion macros for the checker of the console writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH

// Clocked assertion, off while reset is high.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CELL_W  = 16;

  localparam logic [7:0]        BLANK_CHAR = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;
  localparam logic [7:0]        CH_BS      = 8'd8;
  localparam logic [7:0]        CH_LF      = 8'd10;
  localparam logic [7:0]        CH_CR      = 8'd13;

  typedef enum logic [2:0] {
    CMD_PUT      = 3'd0,
    CMD_SET      = 3'd1,
    CMD_PUT_AT   = 3'd2,
    CMD_CLS      = 3'd3,
    CMD_CLR_LINE = 3'd4,
    CMD_FILL     = 3'd5,
    CMD_SCROLL   = 3'd6,
    CMD_READ     = 3'd7
  } cmd_t;

  typedef enum logic {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCR_RD,
    ST_SCR_WR
  } state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic       scrolled;
    logic       ignored;
    logic [7:0] cattr;
    logic [7:0] cchar;
    logic [15:0] linear;
    logic [7:0] row;
    logic [7:0] col;
  } result_t;

endpackage

`default_nettype wire

[hdl/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  item_t             in_item,
  input  logic [7:0]        attr,
  input  logic              out_free,
  output logic              done,
  output result_t           result,
  output mem_req_t          mem,
  input  logic [CELL_W-1:0] rdata
);

  state_t            state, state_next;
  item_t             item, item_next;
  logic              boot, boot_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  f_col, f_col_next, f_c0, f_c0_next, f_clast, f_clast_next;
  logic [ROW_W-1:0]  f_row, f_row_next, f_rlast, f_rlast_next;
  logic [ADDR_W-1:0] f_base, f_base_next;
  logic [CELL_W-1:0] f_value, f_value_next;
  logic [ADDR_W-1:0] s_addr, s_addr_next;
  logic              res_ign, res_ign_next, res_scr, res_scr_next;

  logic [CELL_W-1:0] blank;
  logic              on_screen, f_last, fill_step, col_wrap, last_row;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic [ADDR_W-1:0] ybase, pos_addr, cur_addr, bs_addr;
  logic [8:0]        xe, ye;
  logic              ign_now, scr_now;
  logic [7:0]        rd_char, rd_attr;

  assign blank    = {attr, BLANK_CHAR};
  assign on_screen = (item.x < 8'(COLUMNS)) && (item.y < 8'(ROWS));
  assign ybase    = ADDR_W'(int'(item.y) * COLUMNS);
  assign pos_addr = ybase + ADDR_W'(item.x);
  assign cur_addr = ADDR_W'(int'(cur_row) * COLUMNS) + ADDR_W'(cur_col);
  assign bs_col   = (cur_col != '0) ? cur_col - 1'b1 : COL_W'(COLUMNS - 1);
  assign bs_row   = (cur_col != '0) ? cur_row : cur_row - 1'b1;
  assign bs_addr  = ADDR_W'(int'(bs_row) * COLUMNS) + ADDR_W'(bs_col);
  assign col_wrap = ((COL_W+1)'(cur_col) + 1'b1) >= (COL_W+1)'(COLUMNS);
  assign last_row = cur_row == ROW_W'(ROWS - 1);
  assign xe       = 9'(item.x) + 9'(item.w) - 9'd1;
  assign ye       = 9'(item.y) + 9'(item.h) - 9'd1;
  assign f_last   = (f_col == f_clast) && (f_row == f_rlast);
  assign fill_step = boot || !f_last || out_free;
  assign in_ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      boot    <= 1'b1;
      cur_col <= '0;
      cur_row <= '0;
      f_col   <= '0;
      f_c0    <= '0;
      f_clast <= COL_W'(COLUMNS - 1);
      f_row   <= '0;
      f_rlast <= ROW_W'(ROWS - 1);
      f_base  <= '0;
      f_value <= RESET_CELL;
      s_addr  <= '0;
      res_ign <= 1'b0;
      res_scr <= 1'b0;
    end else begin
      state   <= state_next;
      boot    <= boot_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      f_col   <= f_col_next;
      f_c0    <= f_c0_next;
      f_clast <= f_clast_next;
      f_row   <= f_row_next;
      f_rlast <= f_rlast_next;
      f_base  <= f_base_next;
      f_value <= f_value_next;
      s_addr  <= s_addr_next;
      res_ign <= res_ign_next;
      res_scr <= res_scr_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

  always_comb begin
    state_next   = state;
    item_next    = item;
    boot_next    = boot;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    f_col_next   = f_col;
    f_c0_next    = f_c0;
    f_clast_next = f_clast;
    f_row_next   = f_row;
    f_rlast_next = f_rlast;
    f_base_next  = f_base;
    f_value_next = f_value;
    s_addr_next  = s_addr;
    res_ign_next = res_ign;
    res_scr_next = res_scr;
    mem          = '0;
    done         = 1'b0;
    ign_now      = 1'b0;
    scr_now      = 1'b0;
    rd_char      = '0;
    rd_attr      = '0;
    unique case (state)
      ST_FILL: begin
        mem.we    = fill_step;
        mem.waddr = f_base + ADDR_W'(f_col);
        mem.wdata = f_value;
        if (fill_step) begin
          if (f_last) begin
            boot_next  = 1'b0;
            done       = !boot;
            state_next = ST_IDLE;
          end else if (f_col == f_clast) begin
            f_col_next  = f_c0;
            f_row_next  = f_row + 1'b1;
            f_base_next = f_base + ADDR_W'(COLUMNS);
          end else begin
            f_col_next = f_col + 1'b1;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_next  = in_item;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          done       = 1'b1;
          unique case (item.cmd)
            CMD_PUT: begin
              case (item.ch)
                CH_BS: begin
                  if (cur_col != '0 || cur_row != '0) begin
                    cur_col_next = bs_col;
                    cur_row_next = bs_row;
                    mem.we       = 1'b1;
                    mem.waddr    = bs_addr;
                    mem.wdata    = blank;
                  end
                end
                CH_LF: begin
                  cur_col_next = '0;
                  if (last_row) begin
                    scr_now = 1'b1;
                  end else begin
                    cur_row_next = cur_row + 1'b1;
                  end
                end
                CH_CR: begin
                  cur_col_next = '0;
                end
                default: begin
                  mem.we    = 1'b1;
                  mem.waddr = cur_addr;
                  mem.wdata = {attr, item.ch};
                  if (col_wrap) begin
                    cur_col_next = '0;
                    if (last_row) begin
                      scr_now = 1'b1;
                    end else begin
                      cur_row_next = cur_row + 1'b1;
                    end
                  end else begin
                    cur_col_next = cur_col + 1'b1;
                  end
                end
              endcase
              if (scr_now) begin
                done        = 1'b0;
                s_addr_next = '0;
                state_next  = ST_SCR_RD;
              end
            end
            CMD_SET: begin
              cur_col_next = (item.x >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1) : COL_W'(item.x);
              cur_row_next = (item.y >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(item.y);
            end
            CMD_PUT_AT: begin
              ign_now   = !on_screen;
              mem.we    = on_screen;
              mem.waddr = pos_addr;
              mem.wdata = {attr, item.ch};
            end
            CMD_CLS: begin
              done         = 1'b0;
              cur_col_next = '0;
              cur_row_next = '0;
              f_col_next   = '0;
              f_c0_next    = '0;
              f_clast_next = COL_W'(COLUMNS - 1);
              f_row_next   = '0;
              f_rlast_next = ROW_W'(ROWS - 1);
              f_base_next  = '0;
              f_value_next = blank;
              state_next   = ST_FILL;
            end
            CMD_CLR_LINE: begin
              if (item.y < 8'(ROWS)) begin
                done         = 1'b0;
                f_col_next   = '0;
                f_c0_next    = '0;
                f_clast_next = COL_W'(COLUMNS - 1);
                f_row_next   = ROW_W'(item.y);
                f_rlast_next = ROW_W'(item.y);
                f_base_next  = ybase;
                f_value_next = blank;
                state_next   = ST_FILL;
              end else begin
                ign_now = 1'b1;
              end
            end
            CMD_FILL: begin
              if (!on_screen) begin
                ign_now = 1'b1;
              end else if (item.w != '0 && item.h != '0) begin
                done         = 1'b0;
                f_col_next   = COL_W'(item.x);
                f_c0_next    = COL_W'(item.x);
                f_clast_next = (xe >= 9'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(xe);
                f_row_next   = ROW_W'(item.y);
                f_rlast_next = (ye >= 9'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(ye);
                f_base_next  = ybase;
                f_value_next = {attr, item.ch};
                state_next   = ST_FILL;
              end
            end
            CMD_SCROLL: begin
              done         = 1'b0;
              scr_now      = 1'b1;
              cur_row_next = (cur_row != '0) ? cur_row - 1'b1 : cur_row;
              s_addr_next  = '0;
              state_next   = ST_SCR_RD;
            end
            CMD_READ: begin
              if (on_screen) begin
                done       = 1'b0;
                mem.re     = 1'b1;
                mem.raddr  = pos_addr;
                state_next = ST_READ;
              end else begin
                ign_now = 1'b1;
              end
            end
          endcase
          res_ign_next = ign_now;
          res_scr_next = scr_now;
        end
      end
      ST_READ: begin
        if (out_free) begin
          done       = 1'b1;
          rd_char    = rdata[7:0];
          rd_attr    = rdata[15:8];
          state_next = ST_IDLE;
        end
      end
      ST_SCR_RD: begin
        mem.re     = 1'b1;
        mem.raddr  = s_addr + ADDR_W'(COLUMNS);
        state_next = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        mem.we    = 1'b1;
        mem.waddr = s_addr;
        mem.wdata = rdata;
        if (s_addr == ADDR_W'((ROWS - 1) * COLUMNS - 1)) begin
          f_col_next   = '0;
          f_c0_next    = '0;
          f_clast_next = COL_W'(COLUMNS - 1);
          f_row_next   = ROW_W'(ROWS - 1);
          f_rlast_next = ROW_W'(ROWS - 1);
          f_base_next  = ADDR_W'((ROWS - 1) * COLUMNS);
          f_value_next = blank;
          state_next   = ST_FILL;
        end else begin
          s_addr_next = s_addr + 1'b1;
          state_next  = ST_SCR_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    result          = '0;
    result.col      = 8'(cur_col_next);
    result.row      = 8'(cur_row_next);
    result.linear   = 16'(int'(cur_row_next) * COLUMNS + int'(cur_col_next));
    result.cchar    = rd_char;
    result.cattr    = rd_attr;
    result.ignored  = (state == ST_EXEC) ? ign_now : res_ign;
    result.scrolled = (state == ST_EXEC) ? scr_now : res_scr;
  end

endmodule

`default_nettype wire

[hdl/text_console_cell_writer_core.sv]
// Processing: each item is accepted in ST_IDLE and executed in ST_EXEC, and its result is
//   registered onto m_tdata; a cell read adds ST_READ, clear and fill write their cells in
//   ST_FILL, and a scroll copies rows up (ST_SCR_RD, ST_SCR_WR), then blanks the last row.
// Flow: one item at a time, a new one taken only after the last is done (accept, then execute);
//   reads, clears, fills and scrolls hold the input until they finish.
// Reset: synchronous; after rst falls all CELLS (2000) cells of the RAM are cleared with
//   s_tready low; config writes are taken throughout.
`default_nettype none

module text_console_cell_writer_core import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // char_code, col_x, row_y, rect_width, rect_height
  input  logic [2:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // cursor_col, cursor_row, cursor_linear, cell_char,
                                 // cell_attr, was_ignored, did_scroll, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [3:0]        fg, bg;
  logic              out_free, done;
  item_t             in_item;
  result_t           result, res_q;
  mem_req_t          mem;
  logic [CELL_W-1:0] rdata;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= 4'hF;
      bg <= 4'h0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FG: fg <= cfg_data;
        CFG_BG: bg <= cfg_data;
      endcase
    end
  end

  always_comb begin
    in_item     = '0;
    in_item.cmd = cmd_t'(s_tuser);
    in_item.ch  = s_tdata[7:0];
    in_item.x   = s_tdata[15:8];
    in_item.y   = s_tdata[23:16];
    in_item.w   = s_tdata[31:24];
    in_item.h   = s_tdata[39:32];
  end

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .attr     ({bg, fg}),
    .out_free (out_free),
    .done     (done),
    .result   (result),
    .mem      (mem),
    .rdata    (rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_q <= result;
    end
  end

  assign m_tdata = {6'd0, res_q.scrolled, res_q.ignored, res_q.cattr, res_q.cchar,
                    res_q.linear, res_q.row, res_q.col};

endmodule

`default_nettype wire

[hdl/tcw_chk.sv]
`default_nettype none
`include "text_console_cell_writer_core_macros.svh"

module tcw_chk import tcw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  `TCW_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `TCW_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
  `TCW_ASSERT(a_cursor_range, m_tvalid |-> m_tdata[7:0] < 8'(COLUMNS) && m_tdata[15:8] < 8'(ROWS), "cursor off screen")
  `TCW_ASSERT(a_linear, m_tvalid |-> m_tdata[31:16] == 16'(int'(m_tdata[15:8]) * COLUMNS + int'(m_tdata[7:0])), "cursor linear mismatch")
  `TCW_ASSERT(a_ignored_zero, m_tvalid && m_tdata[48] |-> m_tdata[47:32] == 16'd0, "ignored command returned cell data")

endmodule

bind text_console_cell_writer_core tcw_chk u_chk (.*);

`default_nettype wire
